[src/ctis_pkg.sv]
// Package for the CAN identifier statistics table.
// Holds table sizing constants, the sequencer state type and the cell control struct.
// No dependencies.
package ctis_pkg;

  // Number of table slots.
  localparam int unsigned TableEntries = 16;

  // Field widths of one transaction.
  localparam int unsigned IdW    = 29;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CountW = 32;
  localparam int unsigned OutIdxW  = 4;
  localparam int unsigned OutUsedW = 5;

  // Internal widths derived from the table depth.
  localparam int unsigned IdxW  = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int unsigned UsedW = $clog2(TableEntries + 1);

  // Stream payload widths, padded to whole bytes.
  localparam int unsigned InDataW  = 64;
  localparam int unsigned OutDataW = 48;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } ctis_state_e;

  // Control that the sequencer broadcasts to every cell.
  typedef struct packed {
    logic cmp;     // Latch the identifier compare.
    logic upd;     // Refresh the matching slot.
    logic append;  // Write a new identifier into the first free slot.
  } cell_ctl_t;

endpackage

[src/can_id_stats_table_unit.sv]
// CAN identifier statistics table, top level: sequencer, row of slot cells, result register.
// Flow: the sequencer accepts a transaction, compares it in every cell, then updates the table
// and loads the result register; a new transaction is accepted only after the update step,
// and the update step waits while an earlier result is still not taken.
// Reset: asynchronous, active low; clears the fill count, sequencer and result valid.
// Slot contents are not cleared; slots at or above the fill count are never read.
module can_id_stats_table_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // Fields from bit 0: can_id[28:0], now_ms[60:29], zero pad.
  input  logic [ctis_pkg::InDataW-1:0]    s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // Fields from bit 0: hit[0], entry_index[4:1], entry_count[36:5], dropped[37],
  // entries_used[42:38], zero pad.
  output logic [ctis_pkg::OutDataW-1:0]   m_axis_tdata
);
  import ctis_pkg::*;

  ctis_state_e state_q, state_d;
  cell_ctl_t   ctl;

  logic [IdW-1:0]   key_id_q;
  logic [TimeW-1:0] now_ms_q;
  logic [UsedW-1:0] used_q, used_d;

  logic [TableEntries-1:0] cell_match;
  logic [CountW-1:0]       cell_count [TableEntries];

  logic              any_hit;
  logic              full;
  logic              out_free;
  logic [IdxW-1:0]   hit_idx;
  logic [CountW-1:0] hit_count;

  logic              m_valid_q;
  logic              r_hit_q, r_drop_q;
  logic [IdxW-1:0]   r_idx_q;
  logic [CountW-1:0] r_count_q;
  logic [UsedW-1:0]  r_used_q;
  logic              r_hit_d, r_drop_d;
  logic [IdxW-1:0]   r_idx_d;
  logic [CountW-1:0] r_count_d;

  // Row of slot cells.
  for (genvar k = 0; k < TableEntries; k++) begin : g_cell
    ctis_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .slot_idx_i (IdxW'(k)),
      .used_i     (used_q),
      .key_id_i   (key_id_q),
      .now_ms_i   (now_ms_q),
      .match_o    (cell_match[k]),
      .count_o    (cell_count[k])
    );
  end

  // Collect the single matching slot; the table never holds duplicates.
  always_comb begin
    hit_idx   = '0;
    hit_count = '0;
    for (int k = 0; k < TableEntries; k++) begin
      hit_idx   = hit_idx | (cell_match[k] ? IdxW'(k) : '0);
      hit_count = hit_count | cell_count[k];
    end
  end

  assign any_hit  = |cell_match;
  assign full     = used_q == UsedW'(TableEntries);
  assign out_free = !m_valid_q || m_axis_tready;

  // Sequencer: next state and cell control.
  always_comb begin
    state_d    = state_q;
    ctl        = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        ctl.cmp = 1'b1;
        state_d = ST_UPD;
      end
      ST_UPD: begin
        if (out_free) begin
          ctl.upd    = 1'b1;
          ctl.append = !any_hit && !full;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign s_axis_tready = state_q == ST_IDLE;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Input transaction capture.
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      key_id_q <= s_axis_tdata[IdW-1:0];
      now_ms_q <= s_axis_tdata[IdW+TimeW-1:IdW];
    end
  end

  // Fill count grows by one on every append.
  assign used_d = ctl.append ? used_q + UsedW'(1) : used_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
    end else begin
      used_q <= used_d;
    end
  end

  // Result fields for hit, append and drop.
  always_comb begin
    r_hit_d   = any_hit;
    r_drop_d  = !any_hit && full;
    r_idx_d   = '0;
    r_count_d = '0;
    if (any_hit) begin
      r_idx_d   = hit_idx;
      r_count_d = hit_count;
    end else if (!full) begin
      r_idx_d   = IdxW'(used_q);
      r_count_d = CountW'(1);
    end
  end

  // Result register decouples the table from the output side.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (ctl.upd) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.upd) begin
      r_hit_q   <= r_hit_d;
      r_drop_q  <= r_drop_d;
      r_idx_q   <= r_idx_d;
      r_count_q <= r_count_d;
      r_used_q  <= used_d;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {
    (OutDataW - (1 + OutIdxW + CountW + 1 + OutUsedW))'(0),
    OutUsedW'(r_used_q),
    r_drop_q,
    r_count_q,
    OutIdxW'(r_idx_q),
    r_hit_q
  };

endmodule

[src/ctis_cell.sv]
// One slot of the CAN identifier statistics table.
// Stores identifier, count and last-seen time; compares and updates itself.
// Depends on ctis_pkg.
module ctis_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ctis_pkg::cell_ctl_t           ctl_i,
  input  logic [ctis_pkg::IdxW-1:0]     slot_idx_i,
  input  logic [ctis_pkg::UsedW-1:0]    used_i,
  input  logic [ctis_pkg::IdW-1:0]      key_id_i,
  input  logic [ctis_pkg::TimeW-1:0]    now_ms_i,
  output logic                          match_o,
  output logic [ctis_pkg::CountW-1:0]   count_o
);
  import ctis_pkg::*;

  logic [IdW-1:0]    id_q;
  logic [CountW-1:0] count_q;
  logic [TimeW-1:0]  last_seen_q;
  logic              match_q;
  logic              occupied;
  logic              is_free_slot;
  logic [CountW-1:0] count_inc;

  // A slot is in use when its index lies below the fill count.
  assign occupied     = UsedW'(slot_idx_i) < used_i;
  assign is_free_slot = UsedW'(slot_idx_i) == used_i;

  // Saturating increment of the stored count.
  assign count_inc = (count_q == '1) ? count_q : count_q + CountW'(1);

  // Compare result, held until the update phase.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      match_q <= 1'b0;
    end else if (ctl_i.cmp) begin
      match_q <= occupied && (id_q == key_id_i);
    end
  end

  // Slot contents: refreshed on a hit, written on an append.
  always_ff @(posedge clk_i) begin
    if (ctl_i.upd && match_q) begin
      count_q     <= count_inc;
      last_seen_q <= now_ms_i;
    end else if (ctl_i.append && is_free_slot) begin
      id_q        <= key_id_i;
      count_q     <= CountW'(1);
      last_seen_q <= now_ms_i;
    end
  end

  // Only the matching cell drives a nonzero count toward the collector.
  assign match_o = match_q;
  assign count_o = match_q ? count_inc : '0;

endmodule

[src/ctis_checker.sv]
// Port-level checker for the CAN identifier statistics table, bound to the top level.
// Depends on ctis_pkg and can_id_stats_table_unit.
module ctis_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [ctis_pkg::OutDataW-1:0] m_axis_tdata
);
  import ctis_pkg::*;

  logic              o_hit, o_drop;
  logic [CountW-1:0] o_count;
  logic [OutUsedW-1:0] o_used;

  assign o_hit   = m_axis_tdata[0];
  assign o_count = m_axis_tdata[36:5];
  assign o_drop  = m_axis_tdata[37];
  assign o_used  = m_axis_tdata[42:38];

  // Once reset has been seen at a clock edge, no result is offered in the next cycle.
  a_reset_idle: assert property (@(posedge clk_i) !rst_ni |=> !m_axis_tvalid)
    else $error("result valid during reset");

  // A stalled result keeps its payload.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // A dropped identifier means a full table and no hit.
  a_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && o_drop |->
      !o_hit && o_count == '0 && o_used == OutUsedW'(TableEntries))
    else $error("dropped result inconsistent");

  // A stored identifier always has a nonzero count and a nonzero fill count.
  a_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !o_drop |-> o_count != '0 && o_used != '0 && !(o_hit && o_drop))
    else $error("stored result inconsistent");

endmodule

bind can_id_stats_table_unit ctis_checker u_ctis_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
